@@ rtl/geq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// geq_pkg
// Shared constants, types and arithmetic helpers for the peaking-band
// graphic equalizer.
// ---------------------------------------------------------------------------
package geq_pkg;

   localparam int BANDS_DEF          = 10;
   localparam int CHANNELS_DEF       = 2;
   localparam int COEF_FRAC_BITS_DEF = 28;
   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int NCOEF              = 5;
   localparam int Y_FRAC             = 8;
   localparam int COEF_W             = 32;
   localparam int Y_W                = 32;
   localparam int ACC_W              = 64;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_COEF   = 1'b1;

   // Tap codes inside one band, in MAC order.
   typedef enum logic [2:0] {
      TAP_B0 = 3'd0,
      TAP_B1 = 3'd1,
      TAP_B2 = 3'd2,
      TAP_A1 = 3'd3,
      TAP_A2 = 3'd4
   } tap_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_ROUND,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   // Control handed from the sequencer to every cell of the chain.
   typedef struct packed {
      logic shift;   // rotate coefficients and band histories by one cell
      logic wr_y;    // write new y into head cell's history (for channel)
      logic wr_c;    // write one coefficient into the addressed cell
   } cell_ctl_type;

   // Saturating signed 64-bit add.
   function automatic logic signed [ACC_W-1:0] sat_add64(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W-1:0] s;
      s = a + b;
      if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
         s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

@@ rtl/graphic_equalizer_peaking_biquads.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// graphic_equalizer_peaking_biquads
// Parallel peaking-biquad graphic equalizer over interleaved channels.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries one request: command 0 is an audio sample of
//   req_channel, command 1 loads one Q3.28 coefficient of one band.
//   rsp_ channel returns one equalized sample per accepted audio request
//   whose channel is in range; coefficient loads return nothing.
//   A result comes from the single shared multiply-accumulate unit, which
//   walks five taps per band, each in a multiply and an accumulate step,
//   plus a round and a sum step per band; a divide step then prepares the
//   divide by BANDS, done as a reciprocal multiply. Band state lives in a
//   ring of band cells that rotates one step per band, so the last cell
//   always holds the band being computed. A new sample request is taken
//   only once the sequencer is back in idle; after a coefficient load,
//   req_ready drops while the coefficient is written.
//   The output register frees the datapath: a new request is taken while
//   a finished result waits on rsp_ready, and the sequencer only stalls
//   at its own output step when the register is still full.
//   Reset (synchronous, active high) clears all coefficients, input and
//   band histories and drops any pending result.
// ---------------------------------------------------------------------------
module graphic_equalizer_peaking_biquads #(
   parameter int BANDS          = geq_pkg::BANDS_DEF,
   parameter int CHANNELS       = geq_pkg::CHANNELS_DEF,
   parameter int COEF_FRAC_BITS = geq_pkg::COEF_FRAC_BITS_DEF,
   parameter int SAMPLE_BITS    = geq_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic                          req_channel,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   input  logic [3:0]                    req_band,
   input  logic [2:0]                    req_coef_index,
   input  logic signed [31:0]            req_coef_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   output logic                          rsp_out_channel,
   output logic                          rsp_clipped
);
   import geq_pkg::*;

   localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_W  = Y_W + 6;
   localparam logic signed [SUM_W-1:0] DIV_D = SUM_W'(BANDS * (1 << Y_FRAC));

   // divide by BANDS: clamp, offset to non-negative, reciprocal multiply
   localparam int MQ_W  = SAMPLE_BITS + 5;
   localparam int DIV_K = MQ_W + $clog2(BANDS);
   localparam logic [MQ_W:0] RECIP =
      (MQ_W+1)'(((64'd1 << DIV_K) + 64'(BANDS) - 64'd1) / 64'(BANDS));
   localparam logic signed [SUM_W+1:0] M_HI =
      (SUM_W+2)'(BANDS * (1 << (SAMPLE_BITS - 1)));
   localparam logic signed [SUM_W+1:0] M_LO =
      -(SUM_W+2)'(BANDS * ((1 << (SAMPLE_BITS - 1)) + 1));
   localparam logic signed [SUM_W+1:0] M_OFS =
      (SUM_W+2)'(BANDS * (1 << SAMPLE_BITS));
   localparam logic signed [SAMPLE_BITS+1:0] Q_OFS = (SAMPLE_BITS+2)'(1 << SAMPLE_BITS);
   localparam logic signed [SAMPLE_BITS+1:0] QMAX =
      (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SAMPLE_BITS+1:0] QMIN =
      -(SAMPLE_BITS+2)'(1 << (SAMPLE_BITS - 1));

   state_type state_ff, state_in;

   // request hold
   logic                          ch_ff;
   logic signed [SAMPLE_BITS-1:0] x0_ff;
   logic signed [SAMPLE_BITS-1:0] xh_ff [CHANNELS][2];
   logic [BAND_W-1:0]             bcnt_ff;
   logic [2:0]                    tap_ff;
   logic signed [ACC_W-1:0]       prod_ff, acc_ff;
   logic signed [Y_W-1:0]         y_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic signed [SUM_W+1:0]       num_ff;   // 2*sum + d, divided below
   logic [MQ_W-1:0]               mq_ff;

   logic                          ov_ff;
   logic signed [SAMPLE_BITS-1:0] o_smp_ff;
   logic                          o_ch_ff, o_clip_ff;

   // write-in of a coefficient
   logic                          cw_ff;
   logic [3:0]                    cw_band_ff;
   logic [2:0]                    cw_idx_ff;
   logic signed [31:0]            cw_val_ff;

   // ---------------- cell chain ----------------
   cell_ctl_type             ctl;
   logic signed [COEF_W-1:0] coef_q [BANDS][NCOEF];
   logic signed [Y_W-1:0]    yh_q   [BANDS][CHANNELS][2];

   for (genvar g = 0; g < BANDS; g++) begin : g_cell
      localparam int P = (g == 0) ? BANDS - 1 : g - 1;
      cell_ctl_type cell_ctl;
      // only the head cell takes the fresh band output
      assign cell_ctl = '{shift: ctl.shift, wr_y: (g == 0) ? ctl.wr_y : 1'b0,
                          wr_c: ctl.wr_c};
      geq_cell #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .sel_c     (cw_band_ff == 4'(g)),
         .c_idx     (cw_idx_ff),
         .c_val     (cw_val_ff),
         .ch        (CH_W'(ch_ff)),
         .y_new     (y_ff),
         .coef_prev (coef_q[P]),
         .yh_prev   (yh_q[P]),
         .coef_q    (coef_q[g]),
         .yh_q      (yh_q[g])
      );
   end

   // The head cell (index 0) after BANDS-1 rotations... we compute band in
   // the cell that is about to shift into cell 0, i.e. the last cell.
   logic signed [COEF_W-1:0] cur_c;
   logic signed [Y_W-1:0]    cur_x;
   logic                     cur_sub;
   logic signed [Y_W-1:0]    y1, y2;

   assign y1 = yh_q[BANDS-1][CH_W'(ch_ff)][0];
   assign y2 = yh_q[BANDS-1][CH_W'(ch_ff)][1];

   always_comb begin
      cur_c   = coef_q[BANDS-1][0];
      cur_x   = Y_W'(x0_ff) <<< Y_FRAC;
      cur_sub = 1'b0;
      case (tap_type'(tap_ff))
         TAP_B0: begin cur_c = coef_q[BANDS-1][0]; cur_x = Y_W'(x0_ff) <<< Y_FRAC; end
         TAP_B1: begin
            cur_c = coef_q[BANDS-1][1];
            cur_x = Y_W'(xh_ff[CH_W'(ch_ff)][0]) <<< Y_FRAC;
         end
         TAP_B2: begin
            cur_c = coef_q[BANDS-1][2];
            cur_x = Y_W'(xh_ff[CH_W'(ch_ff)][1]) <<< Y_FRAC;
         end
         TAP_A1: begin cur_c = coef_q[BANDS-1][3]; cur_x = y1; cur_sub = 1'b1; end
         TAP_A2: begin cur_c = coef_q[BANDS-1][4]; cur_x = y2; cur_sub = 1'b1; end
         default: ;
      endcase
   end

   // x values fit in 16+8 bits, y in 32: one 32x32 product, taken in the multiply step.
   logic signed [ACC_W-1:0] mul_p, prod_in;
   assign mul_p   = cur_c * cur_x;
   assign prod_in = cur_sub ? -mul_p : mul_p;

   // rounding and y saturation
   logic signed [ACC_W-1:0] acc_r, y_sh;
   logic signed [Y_W-1:0]   y_sat;
   always_comb begin
      acc_r = sat_add64(acc_ff, ACC_W'(64'sd1) <<< (COEF_FRAC_BITS - 1));
      y_sh  = acc_r >>> COEF_FRAC_BITS;
      if (y_sh > ACC_W'(64'sh7fff_ffff))       y_sat = 32'sh7fff_ffff;
      else if (y_sh < -ACC_W'(64'sh8000_0000)) y_sat = 32'sh8000_0000;
      else                                     y_sat = y_sh[Y_W-1:0];
   end

   // ---------------- sequencer ----------------
   logic acc_req;
   assign acc_req = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (acc_req && req_command == CMD_SAMPLE && 32'(req_channel) < CHANNELS)
                      state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC:   state_in = (tap_ff == 3'(TAP_A2)) ? ST_ROUND : ST_MUL;
         ST_ROUND: state_in = ST_SUM;
         ST_SUM:   state_in = (32'(bcnt_ff) == BANDS - 1) ? ST_DIV : ST_MUL;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT:   if (!ov_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      ctl.shift = (state_ff == ST_SUM);
      ctl.wr_y  = (state_ff == ST_SUM);
      ctl.wr_c  = cw_ff;
   end

   assign req_ready = (state_ff == ST_IDLE) && !cw_ff;

   // quotient = floor(num / (2d)) = floor(floor(num / 2^(Y_FRAC+1)) / BANDS);
   // the clamp keeps saturation intact, the offset keeps the dividend positive
   logic signed [SUM_W+1:0] m_div, m_clamp, m_ofs;
   assign m_div = num_ff >>> (Y_FRAC + 1);
   always_comb begin
      if (m_div > M_HI)      m_clamp = M_HI;
      else if (m_div < M_LO) m_clamp = M_LO;
      else                   m_clamp = m_div;
   end
   assign m_ofs = m_clamp + M_OFS;

   logic [2*MQ_W:0]                q_prod;
   logic signed [SAMPLE_BITS+1:0] q_s;
   assign q_prod = mq_ff * RECIP;
   assign q_s    = $signed(q_prod[DIV_K +: SAMPLE_BITS+2]) - Q_OFS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
         cw_ff    <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            xh_ff[c][0] <= '0;
            xh_ff[c][1] <= '0;
         end
      end else begin
         state_ff <= state_in;
         // a band or index out of range matches no cell slot and is dropped
         cw_ff    <= acc_req && (req_command == CMD_COEF);
         if (acc_req && req_command == CMD_COEF) begin
            cw_band_ff <= req_band;
            cw_idx_ff  <= req_coef_index;
            cw_val_ff  <= req_coef_value;
         end
         if (state_ff == ST_OUT && (!ov_ff || rsp_ready)) ov_ff <= 1'b1;
         else if (rsp_valid && rsp_ready)                  ov_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               bcnt_ff <= '0;
               tap_ff  <= 3'(TAP_B0);
               acc_ff  <= '0;
               ch_ff   <= req_channel;
               x0_ff   <= req_in_sample;
               sum_ff  <= SUM_W'(req_in_sample) <<< Y_FRAC;
            end
            ST_MUL: prod_ff <= prod_in;
            ST_ACC: begin
               acc_ff <= sat_add64(acc_ff, prod_ff);
               tap_ff <= tap_ff + 3'd1;
            end
            ST_ROUND: y_ff <= y_sat;
            ST_SUM: begin
               sum_ff  <= sum_ff + SUM_W'(y_ff);
               acc_ff  <= '0;
               tap_ff  <= 3'(TAP_B0);
               bcnt_ff <= bcnt_ff + 1'b1;
               if (32'(bcnt_ff) == BANDS - 1) begin
                  // numerator of the rounded divide: 2*sum + d
                  num_ff <= ((SUM_W+2)'(sum_ff + SUM_W'(y_ff)) <<< 1) + (SUM_W+2)'(DIV_D);
               end
            end
            ST_DIV: mq_ff <= m_ofs[MQ_W-1:0];
            ST_OUT: begin
               if (!ov_ff || rsp_ready) begin
                  o_ch_ff         <= ch_ff;
                  xh_ff[CH_W'(ch_ff)][1] <= xh_ff[CH_W'(ch_ff)][0];
                  xh_ff[CH_W'(ch_ff)][0] <= x0_ff;
                  if (q_s > QMAX) begin
                     o_smp_ff <= QMAX[SAMPLE_BITS-1:0]; o_clip_ff <= 1'b1;
                  end else if (q_s < QMIN) begin
                     o_smp_ff <= QMIN[SAMPLE_BITS-1:0]; o_clip_ff <= 1'b1;
                  end else begin
                     o_smp_ff <= q_s[SAMPLE_BITS-1:0];  o_clip_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_sample  = o_smp_ff;
   assign rsp_out_channel = o_ch_ff;
   assign rsp_clipped     = o_clip_ff;
endmodule

@@ rtl/geq_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// geq_cell
// One band cell: five coefficients and the y history of every channel.
// Contents rotate to the next cell on shift.
// ---------------------------------------------------------------------------
module geq_cell #(
   parameter int CHANNELS = geq_pkg::CHANNELS_DEF,
   parameter int CH_W     = 1
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  geq_pkg::cell_ctl_type                      ctl,
   input  logic                                       sel_c,
   input  logic [2:0]                                 c_idx,
   input  logic signed [geq_pkg::COEF_W-1:0]          c_val,
   input  logic [CH_W-1:0]                            ch,
   input  logic signed [geq_pkg::Y_W-1:0]             y_new,
   input  logic signed [geq_pkg::COEF_W-1:0]          coef_prev [geq_pkg::NCOEF],
   input  logic signed [geq_pkg::Y_W-1:0]             yh_prev   [CHANNELS][2],
   output logic signed [geq_pkg::COEF_W-1:0]          coef_q    [geq_pkg::NCOEF],
   output logic signed [geq_pkg::Y_W-1:0]             yh_q      [CHANNELS][2]
);
   import geq_pkg::*;

   logic signed [COEF_W-1:0] coef_ff [NCOEF];
   logic signed [Y_W-1:0]    yh_ff   [CHANNELS][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCOEF; i++) coef_ff[i] <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            yh_ff[c][0] <= '0;
            yh_ff[c][1] <= '0;
         end
      end else if (ctl.shift) begin
         coef_ff <= coef_prev;
         for (int c = 0; c < CHANNELS; c++) begin
            // head cell gets the fresh output while the band rotates
            if (ctl.wr_y && ch == CH_W'(c)) begin
               yh_ff[c][0] <= y_new;
               yh_ff[c][1] <= yh_prev[c][0];
            end else begin
               yh_ff[c] <= yh_prev[c];
            end
         end
      end else if (ctl.wr_c && sel_c) begin
         for (int i = 0; i < NCOEF; i++)
            if (c_idx == 3'(i)) coef_ff[i] <= c_val;
      end
   end

   assign coef_q = coef_ff;
   assign yh_q   = yh_ff;
endmodule

@@ rtl/geq_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// geq_checker
// Port-level checks of the equalizer handshakes.
// ---------------------------------------------------------------------------
module geq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_command,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_no_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp after reset");
   a_coef_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command |=> !req_ready)
      else $error("ready during coefficient load");
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_command |=> !req_ready)
      else $error("ready during sample");
endmodule

bind graphic_equalizer_peaking_biquads geq_checker u_geq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready)
);

@@ test/tb_graphic_equalizer_peaking_biquads.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_graphic_equalizer_peaking_biquads
// Self-checking bench for the peaking-biquad graphic equalizer: loads band
// coefficients, streams interleaved samples, and checks every equalized
// sample against a bit-accurate predictor of the band arithmetic.
// ---------------------------------------------------------------------------
module tb_graphic_equalizer_peaking_biquads;
   import geq_pkg::*;

   localparam int NB      = BANDS_DEF;
   localparam int NCH     = CHANNELS_DEF;
   localparam int CFRAC   = COEF_FRAC_BITS_DEF;
   localparam int SW      = SAMPLE_BITS_DEF;
   localparam int WD_LIMIT = 20000;

   typedef struct {
      logic signed [SW-1:0] smp;
      logic                 ch;
      logic                 clip;
   } eq_out_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_command = 1'b0;
   logic              req_channel = 1'b0;
   logic signed [SW-1:0] req_in_sample = '0;
   logic [3:0]        req_band = '0;
   logic [2:0]        req_coef_index = '0;
   logic signed [31:0] req_coef_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_out_sample;
   logic              rsp_out_channel;
   logic              rsp_clipped;

   // predictor state
   logic signed [31:0] coef_mem [NB*NCOEF];
   logic signed [31:0] x_hist   [NCH*2];
   logic signed [31:0] y_hist   [NB*NCH*2];
   eq_out_type         expected_q[$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int n_samples = 0;
   int n_coefs = 0;
   int n_clips = 0;
   int n_checked = 0;
   int idle_cycles = 0;

   graphic_equalizer_peaking_biquads uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Saturating 64-bit add, as the band accumulator does.
   function automatic longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
         s = (a < 0) ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      return s;
   endfunction

   // Update the predictor with one request and queue any expected sample.
   function automatic void equalize(logic cmd, logic ch, logic signed [SW-1:0] xin,
                                    logic [3:0] bnd, logic [2:0] idx,
                                    logic signed [31:0] cval);
      longint x0, x1, x2, acc, y, sum, d, q, num;
      eq_out_type r;
      if (cmd == CMD_COEF) begin
         if (bnd < NB && idx < NCOEF) coef_mem[bnd*NCOEF + idx] = cval;
         return;
      end
      if (ch >= NCH) return;
      x0 = xin;
      x1 = x_hist[ch*2];
      x2 = x_hist[ch*2+1];
      sum = x0 <<< Y_FRAC;
      for (int b = 0; b < NB; b++) begin
         acc = 0;
         acc = add_sat(acc, longint'(coef_mem[b*NCOEF+TAP_B0]) * (x0 <<< Y_FRAC));
         acc = add_sat(acc, longint'(coef_mem[b*NCOEF+TAP_B1]) * (x1 <<< Y_FRAC));
         acc = add_sat(acc, longint'(coef_mem[b*NCOEF+TAP_B2]) * (x2 <<< Y_FRAC));
         acc = add_sat(acc, -(longint'(coef_mem[b*NCOEF+TAP_A1]) *
                              longint'(y_hist[(b*NCH+ch)*2])));
         acc = add_sat(acc, -(longint'(coef_mem[b*NCOEF+TAP_A2]) *
                              longint'(y_hist[(b*NCH+ch)*2+1])));
         acc = add_sat(acc, longint'(1) <<< (CFRAC-1));
         y = acc >>> CFRAC;   // arithmetic shift is a floor
         if (y > 64'sd2147483647) y = 64'sd2147483647;
         if (y < -64'sd2147483648) y = -64'sd2147483648;
         y_hist[(b*NCH+ch)*2+1] = y_hist[(b*NCH+ch)*2];
         y_hist[(b*NCH+ch)*2] = 32'(y);
         sum += y;
      end
      x_hist[ch*2+1] = 32'(x1);
      x_hist[ch*2] = 32'(x0);
      d = longint'(NB) <<< Y_FRAC;
      num = 2*sum + d;
      q = (num >= 0) ? num / (2*d) : -((-num + 2*d - 1) / (2*d));
      r.clip = 1'b0;
      if (q > (64'sd1 <<< (SW-1)) - 1) begin q = (64'sd1 <<< (SW-1)) - 1; r.clip = 1'b1; end
      if (q < -(64'sd1 <<< (SW-1))) begin q = -(64'sd1 <<< (SW-1)); r.clip = 1'b1; end
      r.smp = SW'(q);
      r.ch = ch;
      expected_q.push_back(r);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // Send one request: wait out a random idle gap, hold valid until accepted.
   // Valid stays up after acceptance only until the next request or drain.
   task automatic send_request(logic cmd, logic ch, logic signed [SW-1:0] xin,
                               logic [3:0] bnd, logic [2:0] idx,
                               logic signed [31:0] cval);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_channel    <= ch;
      req_in_sample  <= xin;
      req_band       <= bnd;
      req_coef_index <= idx;
      req_coef_value <= cval;
      do @(posedge clock); while (!req_ready);
      equalize(cmd, ch, xin, bnd, idx, cval);
      if (cmd == CMD_COEF) n_coefs++; else n_samples++;
   endtask

   task automatic send_sample(logic ch, logic signed [SW-1:0] x);
      send_request(CMD_SAMPLE, ch, x, 4'($urandom), 3'($urandom), $urandom);
   endtask

   task automatic load_coef(int bnd, int idx, logic signed [31:0] v);
      send_request(CMD_COEF, 1'($urandom), SW'($urandom), 4'(bnd), 3'(idx), v);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Mildly resonant peaking band: keeps the output audible, not railed.
   task automatic load_gentle_band(int bnd);
      int g;
      g = $urandom_range(1 << 27, 1 << 29);
      load_coef(bnd, TAP_B0, 32'(g));
      load_coef(bnd, TAP_B1, -32'(g) + 32'($urandom_range(0, 1 << 26)));
      load_coef(bnd, TAP_B2, 32'($urandom_range(0, 1 << 27)));
      load_coef(bnd, TAP_A1, -32'($urandom_range(1 << 27, 1 << 28)));
      load_coef(bnd, TAP_A2, 32'($urandom_range(0, 1 << 27)));
   endtask

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_out_sample, 0);
            end else begin
               eq_out_type e;
               e = expected_q.pop_front();
               if (rsp_out_sample !== e.smp) report_mismatch("out_sample", rsp_out_sample, e.smp);
               if (rsp_out_channel !== e.ch) report_mismatch("out_channel", rsp_out_channel, e.ch);
               if (rsp_clipped !== e.clip) report_mismatch("clipped", rsp_clipped, e.clip);
               if (e.clip) n_clips++;
               n_checked++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no request or result moves.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog expired with %0d results pending", expected_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Extremes with zero coefficients, then pass-through and railed gains.
   task automatic test_directed();
      send_sample(1'b0, 16'sh7fff);
      send_sample(1'b1, -16'sh8000);
      send_sample(1'b0, 16'sh0000);
      // unity b0 on band 0, largest b0 on band 9, plus ignored out-of-range writes
      load_coef(0, TAP_B0, 32'sh10000000);
      load_coef(NB-1, TAP_B0, 32'sh7fffffff);
      load_coef(NB, TAP_B0, 32'sh10000000);
      load_coef(15, TAP_A1, 32'sh10000000);
      load_coef(3, 5, 32'sh10000000);
      load_coef(3, 7, -32'sh7fffffff);
      send_sample(1'b0, 16'sh7fff);
      send_sample(1'b1, -16'sh8000);
      send_sample(1'b0, -16'sh0001);
      send_sample(1'b1, 16'sh0001);
      // remaining taps: most negative word on b1 and a1, largest on b2 and a2
      load_coef(1, TAP_B1, -32'sh80000000);
      load_coef(2, TAP_B2, 32'sh7fffffff);
      load_coef(4, TAP_A1, -32'sh80000000);
      load_coef(5, TAP_A2, 32'sh7fffffff);
      send_sample(1'b0, 16'sh1234);
      send_sample(1'b0, -16'sh4321);
      send_sample(1'b1, 16'sh7fff);
      send_sample(1'b1, 16'sh5555);
      send_sample(1'b0, -16'sh2aab);
      wait_drained();
   endtask

   // Random gentle filter banks with random interleaved audio, railed samples and stray coefficient writes.
   task automatic test_random_bank(int n_items);
      int k;
      k = 0;
      for (int b = 0; b < NB; b++) load_gentle_band(b);
      while (k < n_items) begin
         case ($urandom_range(19))
            0: load_coef($urandom_range(15), $urandom_range(7), $urandom);
            1: send_sample(1'($urandom), $urandom_range(1) ? 16'sh7fff : -16'sh8000);
            default: send_sample(1'($urandom), SW'($urandom));
         endcase
         k++;
      end
   endtask

   // Hold off the sender until every pending result has come back.
   task automatic test_drain_pause();
      send_sample(1'b0, SW'($urandom));
      send_sample(1'b1, SW'($urandom));
      wait_drained();
      send_sample(1'b0, SW'($urandom));
   endtask

   initial begin
      for (int i = 0; i < NB*NCOEF; i++) coef_mem[i] = '0;
      for (int i = 0; i < NCH*2; i++) x_hist[i] = '0;
      for (int i = 0; i < NB*NCH*2; i++) y_hist[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 28; recv_idle_pct = 74;
      test_directed();
      test_random_bank(320);
      test_drain_pause();
      send_idle_pct = 74; recv_idle_pct = 28;
      test_random_bank(320);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_bank(320);

      wait_drained();
      repeat (200) @(posedge clock);
      $display("Covered %0d samples and %0d coefficient loads; %0d results checked, %0d clipped.",
               n_samples, n_coefs, n_checked, n_clips);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_q.size());
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/geq_pkg.sv
rtl/geq_cell.sv
rtl/graphic_equalizer_peaking_biquads.sv
rtl/geq_checker.sv
test/tb_graphic_equalizer_peaking_biquads.sv
